@@ design/sbq_pkg.sv @@
// Shared types and constants for the stereo biquad filter.
// No dependencies; used by sbq_lane and stereo_biquad_filter_top.
`default_nettype none

package sbq_pkg;

    // Coefficient register map
    localparam int unsigned NUM_COEFS = 5;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

    // Fractional bits kept in the delay registers
    localparam int unsigned STATE_FRAC = 12;

    // Handshake from the merge stage to a lane
    typedef struct packed {
        logic start;   // latch a new sample and begin the sequence
        logic take;    // the result has been moved to the output register
    } lane_ctrl_t;

    // Status from a lane back to the merge stage
    typedef struct packed {
        logic busy;    // sequence running or result waiting
        logic done;    // result valid and waiting to be taken
    } lane_status_t;

endpackage

`default_nettype wire

@@ design/sbq_lane.sv @@
// One channel of the biquad: a shared multiplier stepped through five products.
// Depends on sbq_pkg for the lane handshake types and register indexes.
`default_nettype none

module sbq_lane #(
    parameter int unsigned SAMPLE_WIDTH = 24,
    parameter int unsigned COEF_WIDTH   = 24
) (
    input  wire logic                                              clk,
    input  wire logic                                              rst_n,
    input  wire sbq_pkg::lane_ctrl_t                               ctrl,
    input  wire logic signed [SAMPLE_WIDTH-1:0]                    sample,
    input  wire logic [sbq_pkg::NUM_COEFS-1:0][COEF_WIDTH-1:0]     coefs,
    output sbq_pkg::lane_status_t                                  status,
    output logic signed [SAMPLE_WIDTH-1:0]                         result
);

    localparam int unsigned SH     = COEF_WIDTH - 2 - sbq_pkg::STATE_FRAC;
    localparam int unsigned PROD_W = COEF_WIDTH + SAMPLE_WIDTH;
    localparam int unsigned RND_W  = PROD_W - SH;
    localparam int unsigned ST_W   = SAMPLE_WIDTH + 16;
    localparam int unsigned ACC_W  = ST_W + 2;
    localparam int unsigned SF     = sbq_pkg::STATE_FRAC;

    localparam logic [PROD_W-1:0] PROD_HALF = {{(PROD_W - SH){1'b0}}, 1'b1, {(SH - 1){1'b0}}};
    localparam logic [ACC_W-1:0]  ACC_HALF  = {{(ACC_W - SF){1'b0}}, 1'b1, {(SF - 1){1'b0}}};

    localparam logic signed [ACC_W-1:0] ST_MAX =
        {{(ACC_W - ST_W + 1){1'b0}}, {(ST_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ST_MIN =
        {{(ACC_W - ST_W + 1){1'b1}}, {(ST_W - 1){1'b0}}};
    localparam logic signed [ACC_W-1:0] Y_MAX =
        {{(ACC_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] Y_MIN =
        {{(ACC_W - SAMPLE_WIDTH + 1){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};

    typedef enum logic [8:0] {
        L_IDLE = 9'b000000001,
        L_B0   = 9'b000000010,
        L_Z1   = 9'b000000100,
        L_Y    = 9'b000001000,
        L_N1A  = 9'b000010000,
        L_N1B  = 9'b000100000,
        L_N2A  = 9'b001000000,
        L_N2B  = 9'b010000000,
        L_DONE = 9'b100000000
    } lane_state_t;

    lane_state_t                    state_reg, state_next;
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [SAMPLE_WIDTH-1:0] y_reg, y_next;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [ACC_W-1:0]        acc_reg, acc_next;
    logic signed [ST_W-1:0]         z1_reg, z1_next;
    logic signed [ST_W-1:0]         z2_reg, z2_next;

    logic signed [COEF_WIDTH-1:0]   mul_coef;
    logic signed [SAMPLE_WIDTH-1:0] mul_data;
    logic                           mul_load;
    logic signed [PROD_W-1:0]       prod_sum;
    logic signed [PROD_W-1:0]       prod_shr;
    logic signed [ACC_W-1:0]        prod_rnd;
    logic signed [ACC_W-1:0]        z1_ext, z2_ext;
    logic signed [ACC_W-1:0]        y_full;
    logic signed [ACC_W-1:0]        n2_full;
    logic signed [ST_W-1:0]         acc_sat, n2_sat;

    // Product rounded half up to state precision, sign-extended to the accumulator.
    assign prod_sum = prod_reg + $signed(PROD_HALF);
    assign prod_shr = prod_sum >>> SH;
    assign prod_rnd = {{(ACC_W - RND_W){prod_shr[RND_W-1]}}, prod_shr[RND_W-1:0]};

    assign z1_ext = {{(ACC_W - ST_W){z1_reg[ST_W-1]}}, z1_reg};
    assign z2_ext = {{(ACC_W - ST_W){z2_reg[ST_W-1]}}, z2_reg};

    // Output sample: round the accumulator to an integer and clamp.
    assign y_full = (acc_reg + $signed(ACC_HALF)) >>> SF;

    assign n2_full = acc_reg - prod_rnd;

    always_comb
    begin
        if (acc_reg > ST_MAX)
            acc_sat = ST_MAX[ST_W-1:0];
        else if (acc_reg < ST_MIN)
            acc_sat = ST_MIN[ST_W-1:0];
        else
            acc_sat = acc_reg[ST_W-1:0];

        if (n2_full > ST_MAX)
            n2_sat = ST_MAX[ST_W-1:0];
        else if (n2_full < ST_MIN)
            n2_sat = ST_MIN[ST_W-1:0];
        else
            n2_sat = n2_full[ST_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        y_next     = y_reg;
        z1_next    = z1_reg;
        z2_next    = z2_reg;
        mul_load   = 1'b0;
        mul_coef   = $signed(coefs[sbq_pkg::REG_B0]);
        mul_data   = x_reg;

        unique case (state_reg)
            L_IDLE:
            begin
                if (ctrl.start)
                    state_next = L_B0;
            end
            L_B0:
            begin
                mul_load   = 1'b1;
                state_next = L_Z1;
            end
            L_Z1:
            begin
                acc_next   = prod_rnd + z1_ext;
                state_next = L_Y;
            end
            L_Y:
            begin
                if (y_full > Y_MAX)
                    y_next = Y_MAX[SAMPLE_WIDTH-1:0];
                else if (y_full < Y_MIN)
                    y_next = Y_MIN[SAMPLE_WIDTH-1:0];
                else
                    y_next = y_full[SAMPLE_WIDTH-1:0];
                mul_load   = 1'b1;
                mul_coef   = $signed(coefs[sbq_pkg::REG_B1]);
                state_next = L_N1A;
            end
            L_N1A:
            begin
                acc_next   = prod_rnd + z2_ext;
                mul_load   = 1'b1;
                mul_coef   = $signed(coefs[sbq_pkg::REG_A1]);
                mul_data   = y_reg;
                state_next = L_N1B;
            end
            L_N1B:
            begin
                acc_next   = acc_reg - prod_rnd;
                mul_load   = 1'b1;
                mul_coef   = $signed(coefs[sbq_pkg::REG_B2]);
                state_next = L_N2A;
            end
            L_N2A:
            begin
                z1_next    = acc_sat;
                acc_next   = prod_rnd;
                mul_load   = 1'b1;
                mul_coef   = $signed(coefs[sbq_pkg::REG_A2]);
                mul_data   = y_reg;
                state_next = L_N2B;
            end
            L_N2B:
            begin
                z2_next    = n2_sat;
                state_next = L_DONE;
            end
            L_DONE:
            begin
                if (ctrl.take)
                    state_next = L_IDLE;
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            z1_reg    <= '0;
            z2_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            z1_reg    <= z1_next;
            z2_reg    <= z2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == L_IDLE && ctrl.start)
            x_reg <= sample;
        if (mul_load)
            prod_reg <= PROD_W'(mul_coef) * PROD_W'(mul_data);
        acc_reg <= acc_next;
        y_reg   <= y_next;
    end

    assign status.busy = (state_reg != L_IDLE);
    assign status.done = (state_reg == L_DONE);
    assign result      = y_reg;

endmodule

`default_nettype wire

@@ design/stereo_biquad_filter_top.sv @@
// Top level of the stereo biquad filter: coefficient registers, two channel
// lanes and the output register that merges their results. Uses sbq_pkg, sbq_lane.
`default_nettype none

//  Channel   Signals                                   Beat contents (low bits first)
//  -------   ---------------------------------------   ------------------------------
//  input     s_axis_tvalid / s_axis_tready / tdata     left_in, right_in, zero pad
//  output    m_axis_tvalid / m_axis_tready / tdata     left_out, right_out, zero pad
//  config    cfg_we / cfg_index / cfg_data             coefficient write, no read-back
//
//  A frame is offered as a result beat once both lanes have finished and the
//  output register is free. The next frame is accepted only after that
//  hand-over, so frames do not overlap; the pace is set by the single multiplier
//  in each lane that forms five products in sequence. The output register
//  holds a finished frame while the next one is accepted and filtered. A lane
//  keeps its result until the output register is free. Reset clears the delay
//  state and restores the pass-through coefficients (b0 = 1.0, others zero).

module stereo_biquad_filter_top #(
    parameter int unsigned SAMPLE_WIDTH = 24,
    parameter int unsigned COEF_WIDTH   = 24
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Input stream
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // Fields: left_in, right_in, zero pad
    input  wire logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // Output stream
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // Fields: left_out, right_out, zero pad
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
    // Coefficient write port
    input  wire logic                                cfg_we,
    input  wire logic [sbq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [COEF_WIDTH-1:0]               cfg_data
);

    localparam int unsigned TDATA_W = ((2*SAMPLE_WIDTH+7)/8)*8;
    localparam logic [COEF_WIDTH-1:0] COEF_ONE =
        {2'b01, {(COEF_WIDTH - 2){1'b0}}};

    // Coefficient registers, indexed by the register map in the package.
    logic [sbq_pkg::NUM_COEFS-1:0][COEF_WIDTH-1:0] coef_reg;

    logic busy_reg;
    logic out_valid_reg;
    logic [SAMPLE_WIDTH-1:0] left_out_reg, right_out_reg;

    sbq_pkg::lane_ctrl_t   lane_ctrl;
    sbq_pkg::lane_status_t left_status, right_status;
    logic signed [SAMPLE_WIDTH-1:0] left_y, right_y;

    logic accept;
    logic take;

    assign s_axis_tready = !busy_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Both lanes run in lockstep; the merge stage takes their results together
    // once the output register is empty or being emptied this cycle.
    assign take = left_status.done && right_status.done
                  && (!out_valid_reg || m_axis_tready);

    assign lane_ctrl.start = accept;
    assign lane_ctrl.take  = take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg[sbq_pkg::REG_B0]  <= COEF_ONE;
            coef_reg[sbq_pkg::REG_B1]  <= '0;
            coef_reg[sbq_pkg::REG_B2]  <= '0;
            coef_reg[sbq_pkg::REG_A1]  <= '0;
            coef_reg[sbq_pkg::REG_A2]  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sbq_pkg::REG_B0: coef_reg[sbq_pkg::REG_B0] <= cfg_data;
                sbq_pkg::REG_B1: coef_reg[sbq_pkg::REG_B1] <= cfg_data;
                sbq_pkg::REG_B2: coef_reg[sbq_pkg::REG_B2] <= cfg_data;
                sbq_pkg::REG_A1: coef_reg[sbq_pkg::REG_A1] <= cfg_data;
                sbq_pkg::REG_A2: coef_reg[sbq_pkg::REG_A2] <= cfg_data;
                default:         ; // indexes past the map are ignored
            endcase
        end
    end

    sbq_lane #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_left_lane (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (lane_ctrl),
        .sample (s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .coefs  (coef_reg),
        .status (left_status),
        .result (left_y)
    );

    sbq_lane #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_right_lane (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (lane_ctrl),
        .sample (s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
        .coefs  (coef_reg),
        .status (right_status),
        .result (right_y)
    );

    // Frame in flight: set on accept, cleared when the results move out.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                busy_reg <= 1'b1;
            else if (take)
                busy_reg <= 1'b0;

            if (take)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            left_out_reg  <= left_y;
            right_out_reg <= right_y;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_W'({right_out_reg, left_out_reg});

`ifndef SYNTHESIS
    // A lane only runs while the merge stage counts a frame in flight.
    a_lane_busy_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        (left_status.busy || right_status.busy) |-> busy_reg)
        else $error("lane active with no frame in flight");

    // The two lanes stay in lockstep.
    a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        left_status.done == right_status.done)
        else $error("left and right lanes out of step");

    // No second frame is accepted before the first has moved out.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_axis_tready)
        else $error("input accepted while a frame is in flight");

    // A new result beat appears only after the lanes handed one over.
    a_out_from_take: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(take))
        else $error("output valid without a lane hand-over");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb_stereo_biquad_filter_top.sv @@
// Self-checking testbench for stereo_biquad_filter_top: directed and random stereo frames
// checked beat by beat against a fixed-point filter predictor kept in this file.
// Depends on sbq_pkg and the stereo_biquad_filter_top RTL only.

module tb_stereo_biquad_filter_top;

    import sbq_pkg::*;

    localparam int SW = 24;                          // sample width
    localparam int CW = 24;                          // coefficient width
    localparam int DW = ((2 * SW + 7) / 8) * 8;      // stream data width
    localparam int DELAY_W = SW + 16;                // width of each delay register
    localparam int PROD_SHIFT = (CW - 2) - STATE_FRAC;

    // Pauses and limits, in clock cycles. The settle time covers any work still
    // running after the last result.
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_GAP = 40;
    localparam int CYCLE_LIMIT = 500000;

    // Random part: seven coefficient settings, 165 frames each.
    localparam int NUM_SETTINGS = 7;
    localparam int FRAMES_PER_SETTING = 165;
    localparam int SWAP_IDLE_AT = 385;
    localparam int NO_IDLE_AT = 770;
    localparam int DRAIN_AT = 450;
    localparam int HOLD_AT = 900;

    // Register indexes that the block must ignore.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(NUM_COEFS);
    localparam logic [CFG_IDX_W-1:0] REG_TOP_CODE = '1;

    localparam int ONE_Q22 = 1 << (CW - 2);
    localparam int S_MAX = (1 << (SW - 1)) - 1;
    localparam int S_MIN = -(1 << (SW - 1));

    typedef enum int {CH_LEFT = 0, CH_RIGHT = 1} channel_e;
    typedef enum logic {ROW_FRAME, ROW_COEF} row_kind_e;

    typedef struct packed {
        logic [SW-1:0] left;
        logic [SW-1:0] right;
    } stereo_t;

    // One line of the directed table. For a frame, a and b are the left and
    // right samples; for a coefficient write, idx and a are used.
    typedef struct packed {
        row_kind_e              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [SW-1:0]          a;
        logic [SW-1:0]          b;
        bit                     typed;
        logic [SW-1:0]          exp_a;
        logic [SW-1:0]          exp_b;
    } dir_row_t;

    localparam int NUM_DIR_ROWS = 36;

    // Directed stimulus. Typed results appear only where the state stays zero and
    // the answer is plain: pass-through after reset, gain extremes that saturate,
    // and the half-up rounding of the output with b0 set to 2^-12.
    dir_row_t dir_rows [0:NUM_DIR_ROWS-1] = '{
        '{ROW_FRAME, REG_B0, S_MAX, S_MIN, 1'b1, S_MAX, S_MIN},
        '{ROW_FRAME, REG_B0, 0, -1, 1'b1, 0, -1},
        '{ROW_FRAME, REG_B0, 1, 5592405, 1'b1, 1, 5592405},
        '{ROW_FRAME, REG_B0, -5592406, S_MAX, 1'b1, -5592406, S_MAX},
        // Writes to indexes past the register file are dropped.
        '{ROW_COEF, REG_UNUSED, 0, 0, 1'b0, 0, 0},
        '{ROW_COEF, REG_TOP_CODE, 0, 0, 1'b0, 0, 0},
        '{ROW_FRAME, REG_B0, 1234, -1234, 1'b1, 1234, -1234},
        // b0 near +2.0: full-scale inputs saturate the output.
        '{ROW_COEF, REG_B0, S_MAX, 0, 1'b0, 0, 0},
        '{ROW_FRAME, REG_B0, S_MAX, S_MIN, 1'b1, S_MAX, S_MIN},
        '{ROW_FRAME, REG_B0, 100, -3, 1'b0, 0, 0},
        // b0 = -2.0 flips the sign and saturates the other way.
        '{ROW_COEF, REG_B0, S_MIN, 0, 1'b0, 0, 0},
        '{ROW_FRAME, REG_B0, S_MIN, S_MAX, 1'b1, S_MAX, S_MIN},
        '{ROW_FRAME, REG_B0, 0, 0, 1'b1, 0, 0},
        // b0 = 2^-12: the output is x / 4096 rounded half up.
        '{ROW_COEF, REG_B0, 1024, 0, 1'b0, 0, 0},
        '{ROW_FRAME, REG_B0, 2048, -2048, 1'b1, 1, 0},
        '{ROW_FRAME, REG_B0, 2047, -2049, 1'b1, 0, -1},
        // Smallest b0: each b0 product sits on the rounding boundary.
        '{ROW_COEF, REG_B0, 1, 0, 1'b0, 0, 0},
        '{ROW_FRAME, REG_B0, 512, -512, 1'b0, 0, 0},
        // A stable low-pass section, driven with an impulse-like pattern.
        '{ROW_COEF, REG_B0, 262144, 0, 1'b0, 0, 0},
        '{ROW_COEF, REG_B1, 524288, 0, 1'b0, 0, 0},
        '{ROW_COEF, REG_B2, 262144, 0, 1'b0, 0, 0},
        '{ROW_COEF, REG_A1, -6710886, 0, 1'b0, 0, 0},
        '{ROW_COEF, REG_A2, 2936013, 0, 1'b0, 0, 0},
        '{ROW_FRAME, REG_B0, S_MAX, S_MIN, 1'b0, 0, 0},
        '{ROW_FRAME, REG_B0, 0, 0, 1'b0, 0, 0},
        '{ROW_FRAME, REG_B0, 0, 0, 1'b0, 0, 0},
        '{ROW_FRAME, REG_B0, S_MIN, S_MAX, 1'b0, 0, 0},
        // Every coefficient at an extreme pushes the delay registers hardest.
        '{ROW_COEF, REG_B0, S_MAX, 0, 1'b0, 0, 0},
        '{ROW_COEF, REG_B1, S_MIN, 0, 1'b0, 0, 0},
        '{ROW_COEF, REG_B2, S_MIN, 0, 1'b0, 0, 0},
        '{ROW_COEF, REG_A1, S_MAX, 0, 1'b0, 0, 0},
        '{ROW_COEF, REG_A2, S_MIN, 0, 1'b0, 0, 0},
        '{ROW_FRAME, REG_B0, S_MAX, S_MIN, 1'b0, 0, 0},
        '{ROW_FRAME, REG_B0, S_MIN, S_MAX, 1'b0, 0, 0},
        '{ROW_FRAME, REG_B0, S_MAX, S_MAX, 1'b0, 0, 0},
        '{ROW_FRAME, REG_B0, -1, 1, 1'b0, 0, 0}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [DW-1:0]          s_axis_tdata;     // left_in [SW-1:0], right_in [2*SW-1:SW]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [DW-1:0]          m_axis_tdata;     // left_out [SW-1:0], right_out [2*SW-1:SW]
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CW-1:0]          cfg_data;

    // Predictor state: coefficients as signed Q2.22 values and the two delay
    // registers of each channel, in sample units with STATE_FRAC fraction bits.
    longint coef [NUM_COEFS];
    longint first_delay [2];
    longint second_delay [2];

    stereo_t pending_out [$];     // predicted output frames, oldest first

    int tx_idle_pct;              // read by the sending process only
    int rx_idle_pct;              // written by set_idle with a nonblocking assignment
    int hold_asked;               // bumped by the sender to request a long output stall
    int frames_sent;
    int results_seen;
    int errors;
    int cfg_writes;
    int cycle_count;

    stereo_biquad_filter_top #(
        .SAMPLE_WIDTH (SW),
        .COEF_WIDTH   (CW)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    // Coefficient times sample, rounded half up to state precision.
    function automatic longint scaled_product(input longint c, input longint s);
        longint p;
        p = c * s;
        return (p + (64'sd1 <<< (PROD_SHIFT - 1))) >>> PROD_SHIFT;
    endfunction

    function automatic longint clamp_signed(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
        begin
            return hi;
        end
        if (v < lo)
        begin
            return lo;
        end
        return v;
    endfunction

    // One transposed direct form II step for one channel. The saturated output
    // sample is also the value fed back through a1 and a2.
    function automatic logic [SW-1:0] filter_sample(input channel_e ch,
                                                    input logic [SW-1:0] x_bits);
        longint x;
        longint acc;
        longint y;
        longint n1;
        longint n2;
        x = longint'($signed(x_bits));
        acc = scaled_product(coef[REG_B0], x) + first_delay[ch];
        y = clamp_signed((acc + (64'sd1 <<< (STATE_FRAC - 1))) >>> STATE_FRAC, SW);
        n1 = scaled_product(coef[REG_B1], x) - scaled_product(coef[REG_A1], y)
             + second_delay[ch];
        n2 = scaled_product(coef[REG_B2], x) - scaled_product(coef[REG_A2], y);
        first_delay[ch] = clamp_signed(n1, DELAY_W);
        second_delay[ch] = clamp_signed(n2, DELAY_W);
        return y[SW-1:0];
    endfunction

    // Mostly full-range samples, with a share of rail values and of small ones
    // that keep a stable section out of saturation.
    function automatic logic [SW-1:0] pick_sample();
        int r;
        r = $urandom_range(99);
        if (r < 10)
        begin
            return SW'(S_MAX);
        end
        if (r < 20)
        begin
            return SW'(S_MIN);
        end
        if (r < 45)
        begin
            return SW'($urandom_range(8191) - 4096);
        end
        return SW'($urandom);
    endfunction

    // Sets the idle rates of both sides; the output side picks its rate up at the next edge.
    task automatic set_idle(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
    endtask

    // Writes one register and leaves the write enable high, so that writes can
    // follow back to back; the next frame lowers it. The predictor drops writes
    // to indexes past the register file, as the block does.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        if (idx < NUM_COEFS)
        begin
            coef[idx] = longint'($signed(val));
        end
        cfg_writes++;
    endtask

    // Offers one frame after a random gap and waits until it is accepted. Valid
    // stays high afterwards so that frames can follow with no bubble; the predicted
    // output is queued at the accepting edge.
    task automatic send_frame(input logic [SW-1:0] left, input logic [SW-1:0] right,
                              input bit typed, input logic [SW-1:0] exp_left,
                              input logic [SW-1:0] exp_right);
        int gap;
        stereo_t predicted;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct)
        begin
            gap++;
        end
        cfg_we <= 1'b0;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata <= {right, left};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        predicted.left = filter_sample(CH_LEFT, left);
        predicted.right = filter_sample(CH_RIGHT, right);
        if (typed)
        begin
            predicted.left = exp_left;
            predicted.right = exp_right;
        end
        pending_out.push_back(predicted);
        frames_sent++;
    endtask

    // Stops offering frames, waits for every predicted frame to come out, then
    // leaves the block time to finish any trailing state update.
    task automatic drain_and_settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_out.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Output side: checks each accepted beat against the oldest prediction and
    // then decides tready for the next edge. A requested hold-off is counted down
    // here, while the sender keeps offering frames.
    int hold_taken;
    int hold_left;

    always @(posedge clk)
    begin
        stereo_t got;
        stereo_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.left = m_axis_tdata[SW-1:0];
                got.right = m_axis_tdata[2*SW-1:SW];
                results_seen++;
                if (pending_out.size() == 0)
                begin
                    if (errors < 10)
                    begin
                        $display("unexpected output beat L=%h R=%h", got.left, got.right);
                    end
                    errors++;
                end
                else
                begin
                    want = pending_out.pop_front();
                    if (got.left !== want.left || got.right !== want.right)
                    begin
                        if (errors < 10)
                        begin
                            $display("mismatch on result %0d: expected L=%h R=%h, got L=%h R=%h",
                                     results_seen, want.left, want.right, got.left, got.right);
                        end
                        errors++;
                    end
                end
            end
            if (hold_taken != hold_asked)
            begin
                hold_taken = hold_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_out.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [CW-1:0] setting [NUM_COEFS];
        bit last_was_frame;
        int n;

        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_B0;
        cfg_data = '0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_asked = 0;
        hold_taken = 0;
        hold_left = 0;
        frames_sent = 0;
        results_seen = 0;
        errors = 0;
        cfg_writes = 0;
        cycle_count = 0;

        // Reset values: pass-through with b0 = 1.0 and empty delay lines.
        for (int k = 0; k < NUM_COEFS; k++)
        begin
            coef[k] = 0;
        end
        coef[REG_B0] = ONE_Q22;
        for (int k = 0; k < 2; k++)
        begin
            first_delay[k] = 0;
            second_delay[k] = 0;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Coefficients change only once the block has gone quiet.
        set_idle(19, 70);
        last_was_frame = 1'b0;
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_COEF)
            begin
                if (last_was_frame)
                begin
                    drain_and_settle();
                end
                cfg_write(dir_rows[i].idx, dir_rows[i].a);
                last_was_frame = 1'b0;
            end
            else
            begin
                send_frame(dir_rows[i].a, dir_rows[i].b, dir_rows[i].typed,
                           dir_rows[i].exp_a, dir_rows[i].exp_b);
                last_was_frame = 1'b1;
            end
        end

        // Random part: one coefficient setting after another, with random frames
        // under each. The idle pattern flips a third of the way in and is dropped
        // for the last third, where the long output stall is requested.
        n = 0;
        for (int s = 0; s < NUM_SETTINGS; s++)
        begin
            drain_and_settle();
            case (s)
                0:
                begin
                    setting[REG_B0] = CW'(262144);
                    setting[REG_B1] = CW'(524288);
                    setting[REG_B2] = CW'(262144);
                    setting[REG_A1] = CW'(-6710886);
                    setting[REG_A2] = CW'(2936013);
                end
                1:
                begin
                    foreach (setting[k])
                    begin
                        setting[k] = CW'(S_MAX);
                    end
                end
                2:
                begin
                    foreach (setting[k])
                    begin
                        setting[k] = CW'(S_MIN);
                    end
                end
                3:
                begin
                    setting[REG_B0] = CW'(S_MAX);
                    setting[REG_B1] = CW'(S_MIN);
                    setting[REG_B2] = CW'(S_MAX);
                    setting[REG_A1] = CW'(S_MIN);
                    setting[REG_A2] = CW'(S_MAX);
                end
                6:
                begin
                    foreach (setting[k])
                    begin
                        setting[k] = '0;
                    end
                    setting[REG_B0] = CW'(ONE_Q22);
                end
                default:
                begin
                    foreach (setting[k])
                    begin
                        setting[k] = CW'($urandom);
                    end
                end
            endcase
            for (int k = REG_B0; k <= REG_A2; k++)
            begin
                cfg_write(CFG_IDX_W'(k), setting[k]);
            end
            cfg_write(REG_UNUSED + CFG_IDX_W'($urandom_range(2)), CW'($urandom));

            for (int k = 0; k < FRAMES_PER_SETTING; k++)
            begin
                if (n == SWAP_IDLE_AT)
                begin
                    set_idle(70, 19);
                end
                if (n == NO_IDLE_AT)
                begin
                    set_idle(0, 0);
                end
                if (n == DRAIN_AT)
                begin
                    drain_and_settle();
                end
                if (n == HOLD_AT)
                begin
                    hold_asked <= hold_asked + 1;
                end
                send_frame(pick_sample(), pick_sample(), 1'b0, '0, '0);
                n++;
            end
        end

        drain_and_settle();

        $display("Sent %0d stereo frames, checked %0d output beats, made %0d register writes",
                 frames_sent, results_seen, cfg_writes);
        $display("over %0d random coefficient settings including both rails; %0d errors.",
                 NUM_SETTINGS, errors);
        if (errors == 0 && pending_out.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/sbq_pkg.sv
design/sbq_lane.sv
design/stereo_biquad_filter_top.sv
tb/sv/tb_stereo_biquad_filter_top.sv
